// ===== design/pow2_bucket_block_allocator_core_assert.svh =====
// Assertion macros for the allocator core checker
`ifndef POW2_BUCKET_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define POW2_BUCKET_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define PBA_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants and types of the power-of-two block allocator.
// ----------------------------------------------------------------------------
package pba_pkg;
  localparam int HEAP_ADDR_BITS  = 16;
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_CLASS      = 12;
  localparam int HEADER_BYTES    = 4;
  localparam int MIN_BLOCK_BYTES = 8;
  localparam int GRAIN_CLASS     = $clog2(MIN_BLOCK_BYTES);
  localparam int IDX_W           = HEAP_ADDR_BITS - GRAIN_CLASS;
  localparam int BLOCK_COUNT     = 1 << IDX_W;
  localparam int CLASS_COUNT     = HEAP_ADDR_BITS + 1;
  localparam int CLS_W           = $clog2(CLASS_COUNT + 1);
  localparam int LINK_W          = IDX_W + 1;
  localparam int OFF_W           = HEAP_ADDR_BITS + 1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0, OP_FREE = 2'd1, OP_SIZE = 2'd2, OP_PAGE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EXHAUSTED = 2'd1, ST_TOO_LARGE = 2'd2
  } status_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [LINK_W-1:0] wlink;
    logic [CLS_W-1:0] wcls;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;
endpackage

// ===== design/pba_block_mem.sv =====
// ----------------------------------------------------------------------------
// pba_block_mem
// Per-block link and class store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pba_block_mem import pba_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [LINK_W-1:0] rlink,
  output logic [CLS_W-1:0]  rcls
);
  logic [LINK_W-1:0] link_mem [BLOCK_COUNT];
  logic [CLS_W-1:0]  cls_mem  [BLOCK_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      link_mem[req.waddr] <= req.wlink;
      cls_mem[req.waddr]  <= req.wcls;
    end
    rlink <= link_mem[req.raddr];
    rcls  <= cls_mem[req.raddr];
  end
endmodule

// ===== design/pow2_bucket_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// pow2_bucket_block_allocator_core
// Segregated power-of-two free-list allocator over a block link memory.
// ----------------------------------------------------------------------------
// Sequence: an alloc or page request passes S_CLASS, S_POP and S_POPW, a free or
// query S_LOOK and S_LOOKW, before the result word is offered in S_OUT; a rejected
// request goes from S_CLASS and an ignored address from S_LOOK straight to S_OUT.
// A refill carves PAGE_BYTES/block size blocks (up to 512), or one big one.
// One word in flight; in_tready returns the cycle after the result is taken.
// Reset: synchronous, active low; all class lists empty, break at zero.
module pow2_bucket_block_allocator_core import pba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] opcode, [17:2] request_bytes, [33:18] user_offset, [39:34] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] result_offset, [32:16] block_bytes, [34:33] status, [39:35] zero
  output logic [39:0] out_tdata
);
  typedef enum logic [2:0] {S_IDLE, S_CLASS, S_CARVE, S_POP, S_POPW, S_LOOK, S_LOOKW, S_OUT}
    state_t;

  state_t state_r;
  logic [LINK_W-1:0] head_r [CLASS_COUNT];
  logic [OFF_W-1:0]  brk_r, carve_r;
  logic [1:0]        op_r;
  logic [17:0]       need_r;
  logic [15:0]       uoff_r;
  logic [CLS_W-1:0]  cls_r;
  logic [IDX_W:0]    k_r;
  logic [IDX_W-1:0]  idx_r;
  logic [15:0]       roff_r;
  logic [16:0]       bytes_r;
  logic [1:0]        stat_r;
  mem_req_t          req;
  logic [LINK_W-1:0] rlink;
  logic [CLS_W-1:0]  rcls;

  pba_block_mem u_mem (.clk(clk), .req(req), .rlink(rlink), .rcls(rcls));

  logic [17:0] req_ext;
  logic [17:0] need_c;
  logic [CLS_W-1:0] cls_c;
  logic [OFF_W:0]   bsz;
  logic [OFF_W:0]   room;
  logic [OFF_W-1:0] base_c;

  always_comb begin
    req_ext = {2'b0, in_tdata[17:2]};
    if (op_t'(in_tdata[1:0]) == OP_PAGE && req_ext < 18'(PAGE_BYTES))
      req_ext = 18'(PAGE_BYTES);
    need_c = req_ext + 18'(HEADER_BYTES);
    if (need_c < 18'(MIN_BLOCK_BYTES)) need_c = 18'(MIN_BLOCK_BYTES);
  end

  always_comb begin
    cls_c = CLS_W'(18);
    for (int c = 17; c >= 0; c--)
      if ((18'(1) << c) >= need_r) cls_c = CLS_W'(c);
  end

  assign bsz  = (OFF_W+1)'(1) << cls_r;
  assign room = (OFF_W+1)'(1 << HEAP_ADDR_BITS) - {1'b0, brk_r};
  assign base_c = 17'(uoff_r) - 17'(HEADER_BYTES);

  always_comb begin
    req = '0;
    req.raddr = head_r[cls_r][IDX_W-1:0];
    unique case (state_r)
      S_CARVE: begin
        req.we    = 1'b1;
        req.waddr = IDX_W'((carve_r + (OFF_W'(k_r - 1'b1) << cls_r)) >> GRAIN_CLASS);
        req.wlink = head_r[cls_r];
        req.wcls  = cls_r;
      end
      S_LOOK:  req.raddr = base_c[GRAIN_CLASS +: IDX_W];
      S_OUT: begin
        req.we    = (op_r == OP_FREE) && (stat_r == ST_OK) && (bytes_r != '0);
        req.waddr = idx_r;
        req.wlink = head_r[cls_r];
        req.wcls  = cls_r;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'b0, stat_r, bytes_r, roff_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      brk_r   <= '0;
      carve_r <= '0;
      for (int c = 0; c < CLASS_COUNT; c++) head_r[c] <= LINK_W'(BLOCK_COUNT);
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          op_r    <= in_tdata[1:0];
          need_r  <= need_c;
          uoff_r  <= in_tdata[33:18];
          roff_r  <= '0;
          bytes_r <= '0;
          stat_r  <= ST_OK;
          state_r <= (op_t'(in_tdata[1:0]) == OP_ALLOC || op_t'(in_tdata[1:0]) == OP_PAGE)
                     ? S_CLASS : S_LOOK;
        end
        S_CLASS: begin
          cls_r <= cls_c;
          if (cls_c > CLS_W'(HEAP_ADDR_BITS)) begin
            stat_r <= ST_TOO_LARGE; state_r <= S_OUT;
          end else if (!head_r[cls_c][IDX_W]) begin
            state_r <= S_POP;
          end else if (cls_c < CLS_W'(PAGE_CLASS)) begin
            if (room < (OFF_W+1)'(PAGE_BYTES)) begin
              stat_r <= ST_EXHAUSTED; state_r <= S_OUT;
            end else begin
              carve_r <= brk_r;
              brk_r   <= brk_r + OFF_W'(PAGE_BYTES);
              k_r     <= (IDX_W+1)'(PAGE_BYTES >> cls_c);
              state_r <= S_CARVE;
            end
          end else if (room < ((OFF_W+1)'(1) << cls_c)) begin
            stat_r <= ST_EXHAUSTED; state_r <= S_OUT;
          end else begin
            carve_r <= brk_r;
            brk_r   <= brk_r + OFF_W'((OFF_W+1)'(1) << cls_c);
            k_r     <= (IDX_W+1)'(1);
            state_r <= S_CARVE;
          end
        end
        S_CARVE: begin
          head_r[cls_r] <= {1'b0, req.waddr};
          k_r <= k_r - 1'b1;
          if (k_r == (IDX_W+1)'(1)) state_r <= S_POP;
        end
        S_POP: begin
          idx_r   <= head_r[cls_r][IDX_W-1:0];
          state_r <= S_POPW;
        end
        S_POPW: begin
          head_r[cls_r] <= rlink;
          roff_r  <= 16'({idx_r, GRAIN_CLASS'(0)} + HEADER_BYTES);
          bytes_r <= bsz[16:0];
          state_r <= S_OUT;
        end
        S_LOOK: begin
          idx_r <= base_c[GRAIN_CLASS +: IDX_W];
          if (uoff_r < 16'(HEADER_BYTES) || base_c[GRAIN_CLASS-1:0] != '0
              || base_c >= brk_r) state_r <= S_OUT;
          else state_r <= S_LOOKW;
        end
        S_LOOKW: begin
          cls_r <= rcls;
          if (rcls < CLS_W'(CLASS_COUNT))
            bytes_r <= 17'((OFF_W+1)'(1) << rcls);
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          if (req.we) head_r[cls_r] <= {1'b0, idx_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/pba_checker.sv =====
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the allocator core, bound to the allocator core.
// ----------------------------------------------------------------------------
`include "pow2_bucket_block_allocator_core_assert.svh"
module pba_checker import pba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  `PBA_ASSERT_IMPL(a_status_code, clk, rst_n, out_tvalid, out_tdata[34:33] != 2'd3)
  `PBA_ASSERT_IMPL(a_err_zero, clk, rst_n, out_tvalid && out_tdata[34:33] != ST_OK, out_tdata[32:0] == '0)
  `PBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind pow2_bucket_block_allocator_core pba_checker u_pba_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
